### hdl/b37nu_pkg.sv
package b37nu_pkg;

  localparam int unsigned MAX_DIGITS  = 13;
  localparam int unsigned DIG_IDX_W   = $clog2(MAX_DIGITS);
  localparam int unsigned NAME_W      = 64;
  localparam int unsigned CHUNK_W     = 16;
  localparam int unsigned NUM_CHUNKS  = NAME_W / CHUNK_W;
  localparam int unsigned CHUNK_IDX_W = $clog2(NUM_CHUNKS);
  localparam int unsigned DIGIT_W     = 6;
  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned RADIX       = 37;

  // Partial dividend is remainder:chunk, always below RADIX * 2**CHUNK_W.
  localparam int unsigned PDIV_W      = DIGIT_W + CHUNK_W;
  localparam int unsigned RECIP_SHIFT = 27;
  localparam int unsigned RECIP_W     = 22;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << RECIP_SHIFT) + RADIX - 1) / RADIX);

  localparam logic [CHAR_W-1:0] CH_SPACE = 7'd32;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] CH_UPPER = 7'd65;
  localparam logic [CHAR_W-1:0] CH_LOWER = 7'd97;
  localparam logic [DIGIT_W-1:0] FIRST_NUM_DIGIT = 6'd27;

  typedef enum logic [1:0] {
    ST_CHAR    = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef struct packed {
    logic                   load;
    logic                   div_step;
    logic [CHUNK_IDX_W-1:0] chunk_idx;
    logic                   digit_wr;
    logic [DIG_IDX_W-1:0]   digit_idx;
    logic                   emit;
    logic                   emit_first;
    logic                   emit_last;
    logic                   special;
    status_e                special_status;
  } cmd_t;

  typedef struct packed {
    logic in_neg;
    logic in_zero;
    logic quot_zero;
  } dp_status_t;

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d,
                                                      input logic upper);
    logic [CHAR_W-1:0] c;
    if (d == '0) begin
      c = CH_SPACE;
    end else if (d >= FIRST_NUM_DIGIT) begin
      c = CH_ZERO + CHAR_W'(d - FIRST_NUM_DIGIT);
    end else begin
      c = (upper ? CH_UPPER : CH_LOWER) + CHAR_W'(d - 6'd1);
    end
    return c;
  endfunction

endpackage

### hdl/b37nu_ctrl.sv
module b37nu_ctrl
  import b37nu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  dp_status_t dp_status_i,
  output cmd_t       cmd_o,
  output logic       busy_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } state_e;

  state_e                 state_q, state_d;
  logic [CHUNK_IDX_W-1:0] chunk_q, chunk_d;
  logic [DIG_IDX_W-1:0]   count_q, count_d;
  logic [DIG_IDX_W-1:0]   pos_q, pos_d;

  always_comb begin
    state_d = state_q;
    chunk_d = chunk_q;
    count_d = count_q;
    pos_d   = pos_q;
    cmd_o   = '0;
    cmd_o.special_status = ST_CHAR;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (dp_status_i.in_neg) begin
            cmd_o.special        = 1'b1;
            cmd_o.special_status = ST_INVALID;
          end else if (dp_status_i.in_zero) begin
            cmd_o.special        = 1'b1;
            cmd_o.special_status = ST_EMPTY;
          end else begin
            cmd_o.load = 1'b1;
            chunk_d    = CHUNK_IDX_W'(NUM_CHUNKS - 1);
            count_d    = '0;
            state_d    = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd_o.div_step  = 1'b1;
        cmd_o.chunk_idx = chunk_q;
        cmd_o.digit_idx = count_q;
        if (chunk_q == '0) begin
          // The remainder of the lowest chunk is the next digit.
          cmd_o.digit_wr = 1'b1;
          count_d        = count_q + 1'b1;
          if (dp_status_i.quot_zero) begin
            pos_d   = count_q;
            state_d = S_EMIT;
          end else begin
            chunk_d = CHUNK_IDX_W'(NUM_CHUNKS - 1);
          end
        end else begin
          chunk_d = chunk_q - 1'b1;
        end
      end
      S_EMIT: begin
        cmd_o.emit       = 1'b1;
        cmd_o.digit_idx  = pos_q;
        cmd_o.emit_first = (pos_q == count_q - 1'b1);
        cmd_o.emit_last  = (pos_q == '0);
        if (pos_q == '0) begin
          state_d = S_IDLE;
        end else begin
          pos_d = pos_q - 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      chunk_q <= '0;
      count_q <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      chunk_q <= chunk_d;
      count_q <= count_d;
      pos_q   <= pos_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

### hdl/b37nu_datapath.sv
module b37nu_datapath
  import b37nu_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic signed [NAME_W-1:0] packed_name_i,
  input  cmd_t                     cmd_i,
  output dp_status_t               status_o,
  output logic                     valid_o,
  output logic [CHAR_W-1:0]        character_o,
  output logic [1:0]               status_code_o,
  output logic                     last_o
);

  logic [NAME_W-1:0]           work_q, work_d;
  logic [DIGIT_W-1:0]          rem_q, rem_d;
  logic [DIGIT_W-1:0]          store_q [MAX_DIGITS];
  logic                        prev_zero_q;
  logic                        valid_q;
  logic [CHAR_W-1:0]           char_q;
  logic [1:0]                  stat_q;
  logic                        last_q;

  logic [CHUNK_W-1:0]          chunk;
  logic [PDIV_W-1:0]           pdiv;
  logic [PDIV_W+RECIP_W-1:0]   prod;
  logic [CHUNK_W-1:0]          quot;
  logic [DIGIT_W-1:0]          rem;

  // One long-division step over a 16-bit chunk: quotient by reciprocal multiply.
  always_comb begin
    chunk = work_q[cmd_i.chunk_idx*CHUNK_W +: CHUNK_W];
    pdiv  = {rem_q, chunk};
    prod  = (PDIV_W+RECIP_W)'(pdiv) * (PDIV_W+RECIP_W)'(RECIP);
    quot  = prod[RECIP_SHIFT +: CHUNK_W];
    rem   = DIGIT_W'(pdiv - PDIV_W'(quot) * PDIV_W'(RADIX));
  end

  always_comb begin
    work_d = work_q;
    rem_d  = rem_q;
    if (cmd_i.load) begin
      work_d = NAME_W'(packed_name_i);
      rem_d  = '0;
    end else if (cmd_i.div_step) begin
      work_d[cmd_i.chunk_idx*CHUNK_W +: CHUNK_W] = quot;
      rem_d = (cmd_i.chunk_idx == '0) ? '0 : rem;
    end
  end

  assign status_o.in_neg    = packed_name_i[NAME_W-1];
  assign status_o.in_zero   = (packed_name_i == '0);
  assign status_o.quot_zero = (work_q[NAME_W-1:CHUNK_W] == '0) && (quot == '0);

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    if (cmd_i.digit_wr) begin
      store_q[cmd_i.digit_idx] <= rem;
    end
    if (cmd_i.emit) begin
      prev_zero_q <= (store_q[cmd_i.digit_idx] == '0);
    end
    if (cmd_i.emit) begin
      char_q <= digit_to_char(store_q[cmd_i.digit_idx], cmd_i.emit_first || prev_zero_q);
      stat_q <= ST_CHAR;
      last_q <= cmd_i.emit_last;
    end else if (cmd_i.special) begin
      char_q <= '0;
      stat_q <= cmd_i.special_status;
      last_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit || cmd_i.special;
    end
  end

  assign valid_o       = valid_q;
  assign character_o   = char_q;
  assign status_code_o = stat_q;
  assign last_o        = last_q;

endmodule

### hdl/base37_name_unpacker.sv
// Base-37 name unpacker.
// Input: raise start_i with packed_name_i while busy_o is low; the item is
// taken at that clock edge. A negative value gives one result with status 2,
// zero gives one result with status 1, both with last_o set, in the cycle after
// the start, and busy_o stays low so a new item may follow at once.
// A positive value raises busy_o while its digits are extracted by long
// division over four 16-bit chunks, one chunk per cycle using a reciprocal
// multiplier. The characters then leave most significant first, one per
// cycle, with valid_o high for exactly one cycle each and last_o on the
// final one. A name has 1 to 13 digits; the block stays busy until its
// last character has been emitted.
// The receiver cannot stall: every result must be taken when valid_o is high.
// Reset clears the controller and valid_o; no clearing pass is needed.
module base37_name_unpacker
  import b37nu_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic signed [NAME_W-1:0] packed_name_i,
  output logic                     valid_o,
  output logic [CHAR_W-1:0]        character_o,
  output logic [1:0]               status_o,
  output logic                     last_o
);

  cmd_t       cmd;
  dp_status_t dp_status;

  b37nu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .dp_status_i (dp_status),
    .cmd_o       (cmd),
    .busy_o      (busy_o)
  );

  b37nu_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .packed_name_i (packed_name_i),
    .cmd_i         (cmd),
    .status_o      (dp_status),
    .valid_o       (valid_o),
    .character_o   (character_o),
    .status_code_o (status_o),
    .last_o        (last_o)
  );

endmodule
